/* hw/rtl/huf_pkg.sv */
`default_nettype none

package huf_pkg;

  // Table geometry and field widths
  localparam int NODE_DEPTH    = 512;
  localparam int BITS_PER_BYTE = 8;
  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int CNT_W         = 32;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int NODE_AW       = $clog2(NODE_DEPTH);
  localparam int BCNT_W        = $clog2(BITS_PER_BYTE);

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

  // One node table entry; a leaf keeps its symbol in the low bits of right
  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // Node table read address source
  typedef enum logic [1:0] {
    RD_CURSOR,
    RD_CHILD,
    RD_ROOT
  } rd_src_t;

  // Walk cursor update source
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_CHILD,
    CUR_ROOT
  } cur_src_t;

  // Controller to datapath
  typedef struct packed {
    logic     mem_wr;
    logic     start;
    logic     byte_ld;
    rd_src_t  rd_src;
    cur_src_t cur_src;
    logic     peek;
    logic     bit_adv;
    logic     emit;
    logic     drain;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_leaf;
    logic bit_last;
    logic cnt_lt_total;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/huf_in_if.sv */
`default_nettype none

interface huf_in_if;
  import huf_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [IDX_W-1:0]    node_index;
  logic                node_is_leaf;
  logic [SYM_W-1:0]    leaf_symbol;
  logic [IDX_W-1:0]    left_child;
  logic [IDX_W-1:0]    right_child;
  logic [SYM_W-1:0]    data_byte;

  modport source (
    output valid, opcode, node_index, node_is_leaf, leaf_symbol,
           left_child, right_child, data_byte,
    input  ready
  );

  modport sink (
    input  valid, opcode, node_index, node_is_leaf, leaf_symbol,
           left_child, right_child, data_byte,
    output ready
  );

endinterface

`default_nettype wire

/* hw/rtl/huf_out_if.sv */
`default_nettype none

interface huf_out_if;
  import huf_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             run_last;
  logic             stream_done;

  modport source (
    output valid, symbol, run_last, stream_done,
    input  ready
  );

  modport sink (
    input  valid, symbol, run_last, stream_done,
    output ready
  );

endinterface

`default_nettype wire

/* hw/rtl/huf_cfg_if.sv */
`default_nettype none

interface huf_cfg_if;
  import huf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

`default_nettype wire

/* hw/rtl/huffman_tree_walk_decoder.sv */
`default_nettype none

// Huffman tree-walk decoder. Opcode 0 beats write one entry of a 512-entry
// node table (a leaf with a symbol, or an internal node with left and right
// child indices); opcode 2 puts the walk cursor at root_index and clears the
// symbol count; opcode 1 beats carry a data byte whose bits are walked MSB
// first, 0 to the left child and 1 to the right. Each leaf reached yields a
// result beat and sends the cursor back to the root; run_last marks the last
// symbol of a data byte, stream_done the symbol that reaches total_symbols,
// and symbols past that count are dropped. Load, start and unused-opcode
// beats are taken in the idle state, which they do not leave. A data byte
// passes through a dispatch step, one step per bit, a final step to
// release the held last symbol, plus one fetch step for every code walk
// that starts on an internal node (at the byte start, and after each leaf,
// dropped or not, reached before the last bit). A root that is itself a
// leaf needs no fetch step; codes one bit long need the most. The pace is
// set by the table's single registered read port: each bit waits for the
// read of the child picked by the previous bit. The newest symbol waits in
// a holding register until the byte ends, so run_last can be set on it;
// the one before sits in the output register. The walk stalls only when a
// leaf yields a symbol while both are full and the output beat is not
// taken, and the release step waits for the output register to free up.
// Table entries never loaded read as garbage. Configuration beats are
// always taken; write them only while the block is idle.

module huffman_tree_walk_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  huf_in_if.sink    in_bus,
  huf_out_if.source out_bus,
  huf_cfg_if.sink   cfg_bus
);
  import huf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // Configuration beats never stall
  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = in_ready;

  // Sequence the walk: dispatch, per-bit steps, last-symbol release
  huf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_opcode (in_bus.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold node table, cursor, counters and the result registers
  huf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_node_index   (in_bus.node_index),
    .in_node_is_leaf (in_bus.node_is_leaf),
    .in_leaf_symbol  (in_bus.leaf_symbol),
    .in_left_child   (in_bus.left_child),
    .in_right_child  (in_bus.right_child),
    .in_data_byte    (in_bus.data_byte),
    .cfg_wr          (cfg_bus.valid),
    .cfg_index       (cfg_bus.index),
    .cfg_data        (cfg_bus.data),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_symbol      (out_bus.symbol),
    .out_run_last    (out_bus.run_last),
    .out_stream_done (out_bus.stream_done)
  );

endmodule

`default_nettype wire

/* hw/rtl/huf_ctrl.sv */
`default_nettype none

module huf_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [huf_pkg::OP_W-1:0] in_opcode,
  output logic                         in_ready,
  input  wire huf_pkg::dp_sts_t        sts,
  output huf_pkg::dp_cmd_t             cmd
);
  import huf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_CHECK = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.rd_src  = RD_CURSOR;
    cmd.cur_src = CUR_HOLD;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD:  cmd.mem_wr = 1'b1;
            OP_START: cmd.start  = 1'b1;
            OP_DATA: begin
              cmd.byte_ld = 1'b1;
              state_nxt   = S_WALK;
            end
            default: ;
          endcase
        end
      end

      // Read data is the entry under the cursor
      S_WALK: begin
        if (sts.rd_leaf) begin
          // Cursor parked on a leaf root: burn the bit, reload the root
          cmd.cur_src = CUR_ROOT;
          cmd.rd_src  = RD_ROOT;
          cmd.bit_adv = 1'b1;
          if (sts.bit_last) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          cmd.cur_src = CUR_CHILD;
          cmd.rd_src  = RD_CHILD;
          state_nxt   = S_CHECK;
        end
      end

      // Read data is the child just taken
      S_CHECK: begin
        if (sts.rd_leaf) begin
          if (sts.cnt_lt_total && sts.pend_valid && !sts.out_free) begin
            cmd.rd_src = RD_CURSOR;
          end else begin
            cmd.emit    = sts.cnt_lt_total;
            cmd.cur_src = CUR_ROOT;
            cmd.rd_src  = RD_ROOT;
            cmd.bit_adv = 1'b1;
            state_nxt   = sts.bit_last ? S_DRAIN : S_WALK;
          end
        end else begin
          cmd.bit_adv = 1'b1;
          if (sts.bit_last) begin
            state_nxt = S_DRAIN;
          end else begin
            cmd.peek    = 1'b1;
            cmd.cur_src = CUR_CHILD;
            cmd.rd_src  = RD_CHILD;
          end
        end
      end

      S_DRAIN: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.drain = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/huf_dpath.sv */
`default_nettype none

module huf_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire huf_pkg::dp_cmd_t              cmd,
  output huf_pkg::dp_sts_t                   sts,
  input  wire logic [huf_pkg::IDX_W-1:0]     in_node_index,
  input  wire logic                          in_node_is_leaf,
  input  wire logic [huf_pkg::SYM_W-1:0]     in_leaf_symbol,
  input  wire logic [huf_pkg::IDX_W-1:0]     in_left_child,
  input  wire logic [huf_pkg::IDX_W-1:0]     in_right_child,
  input  wire logic [huf_pkg::SYM_W-1:0]     in_data_byte,
  input  wire logic                          cfg_wr,
  input  wire logic [huf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [huf_pkg::CNT_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [huf_pkg::SYM_W-1:0]          out_symbol,
  output logic                               out_run_last,
  output logic                               out_stream_done
);
  import huf_pkg::*;

  node_t                mem [NODE_DEPTH];
  node_t                rd_data_r;
  logic                 rd_zero_r;
  node_t                rd_entry;
  node_t                wr_entry;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     child;
  logic                 sel_bit;

  logic [IDX_W-1:0]     root_r;
  logic [CNT_W-1:0]     total_r;
  logic [IDX_W-1:0]     cursor_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_inc;
  logic [BITS_PER_BYTE-1:0] byte_r;
  logic [BCNT_W-1:0]    bit_cnt_r;

  logic                 pend_valid_r;
  logic [SYM_W-1:0]     pend_sym_r;
  logic                 pend_done_r;

  logic                 out_valid_r;
  logic [SYM_W-1:0]     out_sym_r;
  logic                 out_last_r;
  logic                 out_done_r;
  logic                 out_free;

  // Entry selection for the current walk step
  assign rd_entry = rd_zero_r ? '0 : rd_data_r;
  assign sel_bit  = cmd.peek ? byte_r[BITS_PER_BYTE-2] : byte_r[BITS_PER_BYTE-1];
  assign child    = sel_bit ? rd_entry.right : rd_entry.left;

  always_comb begin
    case (cmd.rd_src)
      RD_CHILD: rd_addr = child;
      RD_ROOT:  rd_addr = root_r;
      default:  rd_addr = cursor_r;
    endcase
  end

  always_comb begin
    wr_entry.leaf = in_node_is_leaf;
    if (in_node_is_leaf) begin
      wr_entry.left  = '0;
      wr_entry.right = IDX_W'(in_leaf_symbol);
    end else begin
      wr_entry.left  = in_left_child;
      wr_entry.right = in_right_child;
    end
  end

  // Node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr &&
        ({1'b0, in_node_index} < (IDX_W + 1)'(NODE_DEPTH))) begin
      mem[in_node_index[NODE_AW-1:0]] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr[NODE_AW-1:0]];
    rd_zero_r <= ({1'b0, rd_addr} >= (IDX_W + 1)'(NODE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      total_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROOT:  root_r  <= cfg_data[IDX_W-1:0];
        CFG_TOTAL: total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_inc = count_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      count_r  <= '0;
    end else begin
      if (cmd.start) begin
        cursor_r <= root_r;
        count_r  <= '0;
      end else begin
        case (cmd.cur_src)
          CUR_CHILD: cursor_r <= child;
          CUR_ROOT:  cursor_r <= root_r;
          default: ;
        endcase
        if (cmd.emit) begin
          count_r <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
    end else if (cmd.byte_ld) begin
      bit_cnt_r <= '0;
    end else if (cmd.bit_adv) begin
      bit_cnt_r <= bit_cnt_r + BCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_ld) begin
      byte_r <= in_data_byte;
    end else if (cmd.bit_adv) begin
      byte_r <= byte_r << 1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Pending symbol and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
        end
      end else if (cmd.drain) begin
        pend_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_sym_r  <= rd_entry.right[SYM_W-1:0];
      pend_done_r <= (count_inc == total_r);
    end
    if ((cmd.emit && pend_valid_r) || cmd.drain) begin
      out_sym_r  <= pend_sym_r;
      out_done_r <= pend_done_r;
      out_last_r <= cmd.drain;
    end
  end

  assign sts.rd_leaf      = rd_entry.leaf;
  assign sts.bit_last     = (bit_cnt_r == BCNT_W'(BITS_PER_BYTE - 1));
  assign sts.cnt_lt_total = (count_r < total_r);
  assign sts.pend_valid   = pend_valid_r;
  assign sts.out_free     = out_free;

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_sym_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;

endmodule

`default_nettype wire

/* tb/huf_decode_checker.sv */
module huf_decode_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  huf_in_if         in_mon,
  huf_out_if        out_mon,
  huf_cfg_if        cfg_mon,
  output int        mismatches,
  output int        symbols_left,
  output int        symbols_seen
);
  import huf_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             stream_done;
  } sym_beat_t;

  // Shadow of the decoder state
  node_t            node_mem [NODE_DEPTH];
  logic [IDX_W-1:0] cursor;
  logic [CNT_W-1:0] emitted;
  logic [IDX_W-1:0] root_reg;
  logic [CNT_W-1:0] total_reg;

  sym_beat_t sym_expect_q[$];

  initial begin
    mismatches   = 0;
    symbols_left = 0;
    symbols_seen = 0;
  end

  function automatic void flag(input string msg);
    if (mismatches < 10) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  // Walk one byte MSB first; collect the symbols it releases
  task automatic walk_byte(input logic [SYM_W-1:0] dbyte);
    node_t            here;
    node_t            dest;
    logic [IDX_W-1:0] nxt;
    sym_beat_t        run[$];
    sym_beat_t        b;
    for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
      here = node_mem[cursor];
      if (here.leaf) begin
        // root itself is a leaf: bounce back, emit nothing
        cursor = root_reg;
      end else begin
        nxt    = dbyte[i] ? here.right : here.left;
        dest   = node_mem[nxt];
        cursor = nxt;
        if (dest.leaf) begin
          cursor = root_reg;
          if (emitted < total_reg) begin
            emitted       = emitted + 1'b1;
            b.symbol      = dest.right[SYM_W-1:0];
            b.run_last    = 1'b0;
            b.stream_done = (emitted == total_reg);
            run.push_back(b);
          end
        end
      end
    end
    foreach (run[k]) begin
      b          = run[k];
      b.run_last = (k == run.size() - 1);
      sym_expect_q.push_back(b);
    end
  endtask

  task automatic take_input_beat();
    node_t ent;
    case (in_mon.opcode)
      OP_LOAD: begin
        ent.leaf = in_mon.node_is_leaf;
        if (in_mon.node_is_leaf) begin
          ent.left  = '0;
          ent.right = IDX_W'(in_mon.leaf_symbol);
        end else begin
          ent.left  = in_mon.left_child;
          ent.right = in_mon.right_child;
        end
        node_mem[in_mon.node_index] = ent;
      end
      OP_START: begin
        cursor  = root_reg;
        emitted = '0;
      end
      OP_DATA: walk_byte(in_mon.data_byte);
      default: ;
    endcase
  endtask

  task automatic check_symbol();
    sym_beat_t want;
    if (sym_expect_q.size() == 0) begin
      flag($sformatf("symbol beat %0d: got 0x%02h with nothing expected",
                     symbols_seen, out_mon.symbol));
    end else begin
      want = sym_expect_q.pop_front();
      if (out_mon.symbol !== want.symbol)
        flag($sformatf("symbol beat %0d: symbol expected 0x%02h got 0x%02h",
                       symbols_seen, want.symbol, out_mon.symbol));
      if (out_mon.run_last !== want.run_last)
        flag($sformatf("symbol beat %0d: run_last expected %0b got %0b",
                       symbols_seen, want.run_last, out_mon.run_last));
      if (out_mon.stream_done !== want.stream_done)
        flag($sformatf("symbol beat %0d: stream_done expected %0b got %0b",
                       symbols_seen, want.stream_done, out_mon.stream_done));
    end
    symbols_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cursor    = '0;
      emitted   = '0;
      root_reg  = '0;
      total_reg = '0;
      sym_expect_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_ROOT:  root_reg  = cfg_mon.data[IDX_W-1:0];
          CFG_TOTAL: total_reg = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_input_beat();
      if (out_mon.valid && out_mon.ready) check_symbol();
    end
    symbols_left = sym_expect_q.size();
  end

endmodule

/* tb/tb_huffman_tree_walk_decoder.sv */
module tb_huffman_tree_walk_decoder;
  import huf_pkg::*;

  // Opcode 3 has no meaning in the block; it must be swallowed silently
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int ITEM_GOAL = 170;  // stop opening new phases past this count
  localparam int CALM_AT   = 140;  // from here on, no idling on either side
  localparam int WALK_TAIL = 24;   // covers a byte walk that yields nothing

  logic clk = 1'b0;
  logic rst_n;

  huf_in_if  in_bus ();
  huf_out_if out_bus ();
  huf_cfg_if cfg_bus ();

  int mismatches;
  int symbols_left;
  int symbols_seen;

  // Stimulus bookkeeping
  bit               calm = 1'b0;
  int               n_items;
  int               data_beats;
  int               trees_grown;
  int               reg_settings;
  bit               written [NODE_DEPTH];
  logic [IDX_W-1:0] written_list[$];

  always #5 clk = ~clk;

  huffman_tree_walk_decoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  huf_decode_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_mon      (cfg_bus),
    .mismatches   (mismatches),
    .symbols_left (symbols_left),
    .symbols_seen (symbols_seen)
  );

  // Hard stop in case the block hangs; the slowest legal run is far shorter
  initial begin
    #1_000_000;
    $display("huffman_tree_walk_decoder: mismatch");
    $finish;
  end

  // Result side: alternate ready stretches with short stall bursts; the
  // stretches are often long enough to leave whole bytes unstalled.
  initial begin
    int hold;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        hold = $urandom_range(1, 5);
      end else begin
        out_bus.ready <= 1'b1;
        hold = $urandom_range(1, 16);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Random field values at their exact widths
  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, NODE_DEPTH - 1));
  endfunction

  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Every entry that may ever be reached is written first: internal nodes
  // only point at written entries and the root only moves to one, so the
  // walk never lands on an entry with no defined content.
  function automatic void note_written(input logic [IDX_W-1:0] idx);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endfunction

  function automatic logic [IDX_W-1:0] pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // Present one beat and hold it until taken. Valid stays high into the
  // next beat unless a gap is inserted, so it never drops and rises in one
  // step.
  task automatic push_beat(input logic [OP_W-1:0]  op,
                           input logic [IDX_W-1:0] idx,
                           input logic             leaf,
                           input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] lch,
                           input logic [IDX_W-1:0] rch,
                           input logic [SYM_W-1:0] dbyte);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= op;
    in_bus.node_index   <= idx;
    in_bus.node_is_leaf <= leaf;
    in_bus.leaf_symbol  <= sym;
    in_bus.left_child   <= lch;
    in_bus.right_child  <= rch;
    in_bus.data_byte    <= dbyte;
    do @(posedge clk); while (!in_bus.ready);
    if (op != OP_NOP) n_items++;
  endtask

  // Fields an opcode ignores are filled with noise
  task automatic load_leaf(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] sym);
    push_beat(OP_LOAD, idx, 1'b1, sym, rand_idx(), rand_idx(), rand_sym());
    note_written(idx);
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] lch,
                           input logic [IDX_W-1:0] rch);
    push_beat(OP_LOAD, idx, 1'b0, rand_sym(), lch, rch, rand_sym());
    note_written(idx);
  endtask

  task automatic feed_byte(input logic [SYM_W-1:0] dbyte);
    push_beat(OP_DATA, rand_idx(), rand_bit(), rand_sym(), rand_idx(),
              rand_idx(), dbyte);
    data_beats++;
  endtask

  task automatic open_stream();
    push_beat(OP_START, rand_idx(), rand_bit(), rand_sym(), rand_idx(),
              rand_idx(), rand_sym());
  endtask

  task automatic send_noop();
    push_beat(OP_NOP, rand_idx(), rand_bit(), rand_sym(), rand_idx(),
              rand_idx(), rand_sym());
  endtask

  // Hold off new beats until every predicted symbol is out, then give a
  // byte that yields nothing time to finish its walk.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (symbols_left != 0);
    repeat (WALK_TAIL) @(posedge clk);
  endtask

  // Only call on an idle block; valid is held across both writes
  task automatic write_regs(input logic [IDX_W-1:0] root, input logic [CNT_W-1:0] total);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_ROOT;
    cfg_bus.data  <= CNT_W'(root);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= CFG_TOTAL;
    cfg_bus.data  <= total;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    reg_settings++;
  endtask

  // Build a random tree bottom-up: load the leaves, then merge random pairs
  // under fresh internal nodes until one node is left. Random pairing gives
  // lopsided trees, so codes often run across byte boundaries.
  task automatic grow_tree(input int n_leaves, output logic [IDX_W-1:0] top_idx);
    logic [IDX_W-1:0] pool[$];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               k;
    for (int n = 0; n < n_leaves; n++) begin
      idx = rand_idx();
      load_leaf(idx, rand_sym());
      pool.push_back(idx);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(0, pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      idx = rand_idx();
      load_node(idx, a, b);
      pool.push_back(idx);
    end
    top_idx = pool[0];
    trees_grown++;
  endtask

  initial begin
    logic [IDX_W-1:0] tree_root;
    logic [IDX_W-1:0] root_pick;
    logic [CNT_W-1:0] total_pick;

    n_items      = 0;
    data_beats   = 0;
    trees_grown  = 0;
    reg_settings = 0;

    // Drive every input to a known value before the first edge
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.opcode       <= OP_LOAD;
    in_bus.node_index   <= '0;
    in_bus.node_is_leaf <= 1'b0;
    in_bus.leaf_symbol  <= '0;
    in_bus.left_child   <= '0;
    in_bus.right_child  <= '0;
    in_bus.data_byte    <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_ROOT;
    cfg_bus.data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed part ----
    // Two-leaf tree at entry 0, the reset root, with the symbol extremes.
    load_leaf(9'd1, 8'h00);
    load_leaf(9'd2, 8'hFF);
    load_node(9'd0, 9'd1, 9'd2);
    // Total is still zero from reset: every symbol is dropped.
    feed_byte(8'hA5);
    send_noop();
    drain_results();

    // Count reached: 8 + 4 symbols fill a total of 12, the rest are dropped.
    write_regs(9'd0, 32'd12);
    open_stream();
    feed_byte(8'hFF);
    feed_byte(8'h00);
    feed_byte(8'h0F);
    drain_results();

    // Root at the top entry, first as a leaf (bits bounce, nothing comes
    // out), then as an internal node that loops back to itself on a 1 bit.
    write_regs(9'd511, 32'hFFFF_FFFF);
    load_leaf(9'd511, 8'h5A);
    open_stream();
    feed_byte(8'h3C);
    load_leaf(9'd256, 8'h80);
    load_node(9'd511, 9'd256, 9'd511);
    feed_byte(8'hAA);
    feed_byte(8'h7F);

    // ---- Random phases ----
    // Each phase grows a fresh tree, settles, reprograms both registers and
    // decodes a burst of bytes. Noise beats are mixed into the burst:
    // stray loads, unused opcodes and restarts in the middle of a code.
    while (n_items < ITEM_GOAL) begin
      calm = (n_items >= CALM_AT);
      grow_tree($urandom_range(2, 12), tree_root);
      drain_results();

      case ($urandom_range(0, 7))
        0:       total_pick = '0;
        1:       total_pick = 32'hFFFF_FFFF;
        2, 3:    total_pick = $urandom_range(1, 24);
        default: total_pick = $urandom;
      endcase
      // Now and then root the walk at any written entry, a leaf included
      root_pick = ($urandom_range(0, 5) == 0) ? pick_written() : tree_root;
      write_regs(root_pick, total_pick);

      // Skip the restart once in a while: the walk and count carry over
      if ($urandom_range(0, 7) != 0) open_stream();

      repeat ($urandom_range(4, 12)) begin
        case ($urandom_range(0, 9))
          0:       send_noop();
          1:       load_leaf(rand_idx(), rand_sym());
          2:       load_node(rand_idx(), pick_written(), pick_written());
          3:       open_stream();
          default: feed_byte(rand_sym());
        endcase
      end
    end

    drain_results();

    $display("covered %0d input beats: %0d data bytes, %0d trees, %0d register settings",
             n_items, data_beats, trees_grown, reg_settings);
    $display("checked %0d symbol beats, %0d field errors", symbols_seen, mismatches);
    if (mismatches == 0 && symbols_left == 0) begin
      $display("huffman_tree_walk_decoder: match");
    end else begin
      $display("huffman_tree_walk_decoder: mismatch");
    end
    $finish;
  end

endmodule
